// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define RBSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rbsc assertion failed");

// condition in one cycle implies consequence in the next
`define RBSC_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("rbsc assertion failed");

`endif

// File: src/rbsc_pkg.sv
// ---------------------------------------------------------------------------
// rbsc_pkg
// types, request codes and helpers for the range bit set/clear/flip/count core
// ---------------------------------------------------------------------------
`default_nettype none

package rbsc_pkg;

   localparam int unsigned POS_W   = 10;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BIT_W   = 5;
   localparam int unsigned POP_W   = 6;

   localparam logic [1:0] OP_SET   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_FLIP  = 2'd2;
   localparam logic [1:0] OP_COUNT = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_FINISH
   } rbsc_state_type;

   function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] w);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + POP_W'(w[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: src/rbsc_req_if.sv
// ---------------------------------------------------------------------------
// rbsc_req_if
// request channel: operation code and inclusive bit range
// ---------------------------------------------------------------------------
`default_nettype none

interface rbsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [9:0] range_low;
   logic [9:0] range_high;

   modport source (output valid, output req_type, output range_low,
                   output range_high, input ready);
   modport sink (input valid, input req_type, input range_low,
                 input range_high, output ready);
endinterface

`default_nettype wire

// File: src/rbsc_rsp_if.sv
// ---------------------------------------------------------------------------
// rbsc_rsp_if
// result channel: number of ones in the counted range
// ---------------------------------------------------------------------------
`default_nettype none

interface rbsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] ones_count;

   modport source (output valid, output ones_count, input ready);
   modport sink (input valid, input ones_count, output ready);
endinterface

`default_nettype wire

// File: src/rbsc_ram.sv
// ---------------------------------------------------------------------------
// rbsc_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module rbsc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// File: src/range_bit_set_clear_flip_count_core.sv
// each 32-bit word the clamped range touches takes a read and a modify state,
// then the request ends in a finish state
// throughput: one request at a time, paced by the word ram read-modify-write
// reset and any csr write clear the row through per-word valid bits
// ---------------------------------------------------------------------------
// range_bit_set_clear_flip_count_core
// bit row with range set, clear, invert and ones count, swept a word at a time
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module range_bit_set_clear_flip_count_core #(
   parameter int unsigned POSITIONS = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   rbsc_req_if.sink                      req_ch,
   rbsc_rsp_if.source                    rsp_ch,
   input  wire logic                     csr_we,
   input  wire logic [rbsc_pkg::POS_W-1:0] csr_wdata
);
   import rbsc_pkg::*;

   localparam int unsigned LIMIT = (POSITIONS - 1 > 1023) ? 1023 : POSITIONS - 1;
   localparam int unsigned WORDS = (LIMIT + WORD_W) / WORD_W;
   localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [POS_W-1:0] LAST_MAX = POS_W'(LIMIT);

   rbsc_state_type       state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [POS_W-1:0]     lo_ff, lo_in, hi_ff, hi_in, last_ff;
   logic [AW-1:0]        w_ff, w_in;
   logic [COUNT_W-1:0]   acc_ff, acc_in;
   logic [WORDS-1:0]     valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0]    ram_q, word, mask, new_word;
   logic                 ram_we;
   logic [BIT_W-1:0]     lb, hb;
   logic [POS_W-1:0]     hi_clamp;
   logic [AW-1:0]        lo_w, hi_w;

   rbsc_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_row (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (w_ff),
      .wr_data (new_word),
      .rd_addr (w_ff),
      .rd_data (ram_q)
   );

   assign lo_w = AW'(lo_ff >> BIT_W);
   assign hi_w = AW'(hi_ff >> BIT_W);

   // bits of the current word that fall inside the range, and the word after the operation
   always_comb begin
      lb = (w_ff == lo_w) ? lo_ff[BIT_W-1:0] : '0;
      hb = (w_ff == hi_w) ? hi_ff[BIT_W-1:0] : '1;
      mask = ({WORD_W{1'b1}} << lb) & ({WORD_W{1'b1}} >> (5'd31 - hb));
      word = valid_ff[w_ff] ? ram_q : '0;
      case (op_ff)
         OP_SET:   new_word = word | mask;
         OP_CLEAR: new_word = word & ~mask;
         OP_FLIP:  new_word = word ^ mask;
         default:  new_word = word;
      endcase
   end

   assign hi_clamp = (req_ch.range_high > last_ff) ? last_ff : req_ch.range_high;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      ram_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in  = req_ch.req_type;
               lo_in  = req_ch.range_low;
               hi_in  = hi_clamp;
               acc_in = '0;
               w_in   = AW'(req_ch.range_low >> BIT_W);
               state_in = (req_ch.range_low > hi_clamp) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            ram_we = (op_ff != OP_COUNT);
            acc_in = acc_ff + COUNT_W'(popcount(word & mask));
            if (w_ff == hi_w) begin
               state_in = ST_FINISH;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (op_ff != OP_COUNT) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         last_ff      <= LAST_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            valid_ff <= '0;
            last_ff  <= (csr_wdata > LAST_MAX) ? LAST_MAX : csr_wdata;
         end else if (ram_we) begin
            valid_ff[w_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.ones_count = rsp_data_ff;

   `RBSC_ASSERT(a_word_in_range, clock, reset, (state_ff == ST_MODIFY) |-> (w_ff <= hi_w))
   `RBSC_ASSERT(a_count_bound, clock, reset, (acc_ff <= 11'd1024) || (state_ff == ST_IDLE))
   `RBSC_ASSERT_NEXT(a_csr_clears, clock, reset, csr_we, valid_ff == '0)
endmodule

`default_nettype wire
